// ===== hdl/sac_pkg.sv =====
package sac_pkg;

	// default build sizes
	localparam int DEF_MAX_SETS  = 256;
	localparam int DEF_MAX_WAYS  = 4;
	localparam int DEF_ADDR_BITS = 32;

	localparam int CNT_W  = 32;
	localparam int ADDR_W = 32;

	// configuration register indexes
	localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
	localparam logic [1:0] CFG_WAYS        = 2'd2;

	// configuration reset values
	localparam logic [3:0] RST_OFFSET_BITS = 4'd6;
	localparam logic [3:0] RST_INDEX_BITS  = 4'd8;
	localparam logic [2:0] RST_WAYS        = 3'd4;

	// access kinds
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_FETCH = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] address;
	} sac_req_t;

	typedef struct packed {
		logic             hit;
		logic             wrote_back;
		logic [1:0]       way_used;
		logic [CNT_W-1:0] access_count;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] miss_count;
		logic [CNT_W-1:0] writeback_count;
	} sac_rsp_t;

	typedef struct packed {
		logic [1:0] index;
		logic [3:0] value;
	} sac_cfg_wr_t;

	typedef struct packed {
		logic [3:0] offset_bits;
		logic [3:0] index_bits;
		logic [2:0] ways;
	} sac_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic lookup;   // word accepted: latch it and read the set
		logic commit;   // update the set and load the result register
	} sac_cmd_t;

endpackage

// ===== hdl/sac_chan_if.sv =====
interface sac_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sac_cfg_regs.sv =====
module sac_cfg_regs import sac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sac_chan_if.sink    cfg,
	output sac_cfg_t    regs
);

	sac_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.offset_bits <= RST_OFFSET_BITS;
			regs_q.index_bits  <= RST_INDEX_BITS;
			regs_q.ways        <= RST_WAYS;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_OFFSET_BITS: regs_q.offset_bits <= cfg.data.value;
				CFG_INDEX_BITS:  regs_q.index_bits  <= cfg.data.value;
				CFG_WAYS:        regs_q.ways        <= cfg.data.value[2:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/sac_ctrl.sv =====
module sac_ctrl import sac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output sac_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPD  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic accept;
	logic commit;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	// result register free or draining this cycle
	assign commit    = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign cmd.lookup = accept;
	assign cmd.commit = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_UPD;
				ST_UPD:  if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/sac_datapath.sv =====
module sac_datapath import sac_pkg::*; #(
	parameter int MAX_SETS  = DEF_MAX_SETS,
	parameter int MAX_WAYS  = DEF_MAX_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  sac_cmd_t cmd,
	input  sac_cfg_t cfg,
	input  sac_req_t req,
	output sac_rsp_t rsp
);

	localparam int TAG_W   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;   // floor log2
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WC_W    = $clog2(MAX_WAYS + 1) > 3 ? $clog2(MAX_WAYS + 1) : 3;

	// address split
	logic [3:0]       sib_eff;
	logic [TAG_W-1:0] addr_m;
	logic [TAG_W-1:0] shifted;
	logic [TAG_W-1:0] set_full;
	logic [TAG_W-1:0] tag_in;
	logic [SET_W-1:0] set_rd;
	logic [WC_W-1:0]  ways_raw;
	logic [WC_W-1:0]  ways_eff;

	// lookup registers
	logic [TAG_W-1:0]          tag_q;
	logic [SET_W-1:0]          set_q;
	logic                      is_write_q;
	logic [MAX_WAYS*TAG_W-1:0] tag_rd_q;
	logic [MAX_WAYS-1:0]       dirty_rd_q;
	logic [MAX_WAYS*WAY_W-1:0] lru_rd_q;
	logic [MAX_WAYS-1:0]       valid_rd_q;
	logic                      used_rd_q;

	// storage
	logic                      used_q [MAX_SETS];
	logic [MAX_WAYS-1:0]       valid_mem [MAX_SETS];
	logic [MAX_WAYS*TAG_W-1:0] tag_mem [MAX_SETS];
	logic [MAX_WAYS-1:0]       dirty_mem [MAX_SETS];
	logic [MAX_WAYS*WAY_W-1:0] lru_mem [MAX_SETS];

	// update
	logic [MAX_WAYS-1:0]       valid_row;
	logic                      touched;
	logic [WAY_W-1:0]          order [MAX_WAYS];
	logic [MAX_WAYS-1:0]       hit_vec;
	logic [MAX_WAYS-1:0]       inv_vec;
	logic                      hit;
	logic                      inv_any;
	logic [WAY_W-1:0]          hit_way;
	logic [WAY_W-1:0]          inv_way;
	logic [WAY_W-1:0]          lru_way;
	logic [WAY_W-1:0]          way;
	logic [WAY_W+1:0]          way_x;
	logic [WAY_W-1:0]          pos;
	logic                      wb;
	logic [MAX_WAYS-1:0]       valid_new;
	logic [MAX_WAYS-1:0]       dirty_new;
	logic [MAX_WAYS*TAG_W-1:0] tag_new;
	logic [MAX_WAYS*WAY_W-1:0] lru_new;

	logic [CNT_W-1:0] acc_cnt_q, hit_cnt_q, miss_cnt_q, wb_cnt_q;
	logic [CNT_W-1:0] acc_nxt, hit_nxt, miss_nxt, wb_nxt;
	sac_rsp_t         rsp_q;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// sets beyond the build are clipped; ways clamped to 1..MAX_WAYS
	assign sib_eff  = (int'(cfg.index_bits) > SET_LOG) ? 4'(SET_LOG) : cfg.index_bits;
	assign ways_raw = WC_W'(cfg.ways);
	assign ways_eff = (ways_raw == '0) ? WC_W'(1) :
		(int'(ways_raw) > MAX_WAYS) ? WC_W'(MAX_WAYS) : ways_raw;

	assign addr_m   = req.address[TAG_W-1:0];
	assign shifted  = addr_m >> cfg.offset_bits;
	assign set_full = shifted & ~({TAG_W{1'b1}} << sib_eff);
	assign tag_in   = shifted >> sib_eff;
	assign set_rd   = set_full[SET_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			tag_q      <= tag_in;
			set_q      <= set_rd;
			is_write_q <= (req.action == ACT_WRITE);
			tag_rd_q   <= tag_mem[set_rd];
			dirty_rd_q <= dirty_mem[set_rd];
			lru_rd_q   <= lru_mem[set_rd];
			valid_rd_q <= valid_mem[set_rd];
			used_rd_q  <= used_q[set_rd];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			tag_mem[set_q]   <= tag_new;
			dirty_mem[set_q] <= dirty_new;
			lru_mem[set_q]   <= lru_new;
			valid_mem[set_q] <= valid_new;
		end
	end

	// one written flag per set; an unwritten set reads as all lines invalid
	// with its LRU order at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SETS; s++)
				used_q[s] <= 1'b0;
		end else if (cmd.commit) begin
			used_q[set_q] <= 1'b1;
		end
	end

	assign valid_row = used_rd_q ? valid_rd_q : '0;
	assign touched   = used_rd_q;

	always_comb begin
		hit     = 1'b0;
		inv_any = 1'b0;
		hit_way = '0;
		inv_way = '0;
		lru_way = '0;
		pos     = '0;
		for (int k = 0; k < MAX_WAYS; k++) begin
			order[k]   = touched ? lru_rd_q[k*WAY_W +: WAY_W] : WAY_W'(k);
			hit_vec[k] = (k < int'(ways_eff)) && valid_row[k] &&
				(tag_rd_q[k*TAG_W +: TAG_W] == tag_q);
			inv_vec[k] = (k < int'(ways_eff)) && !valid_row[k];
		end
		// lowest way wins
		for (int k = MAX_WAYS - 1; k >= 0; k--) begin
			if (hit_vec[k]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(k);
			end
			if (inv_vec[k]) begin
				inv_any = 1'b1;
				inv_way = WAY_W'(k);
			end
		end
		// oldest way still in use
		for (int k = 0; k < MAX_WAYS; k++) begin
			if (int'(order[k]) < int'(ways_eff))
				lru_way = order[k];
		end
		way = hit ? hit_way : (inv_any ? inv_way : lru_way);
		wb  = !hit && !inv_any && valid_row[lru_way] && dirty_rd_q[lru_way];

		for (int k = MAX_WAYS - 1; k >= 0; k--) begin
			if (order[k] == way)
				pos = WAY_W'(k);
		end
		// promote to most recent
		for (int k = 0; k < MAX_WAYS; k++) begin
			if (k == 0)
				lru_new[k*WAY_W +: WAY_W] = way;
			else if (k <= int'(pos))
				lru_new[k*WAY_W +: WAY_W] = order[k-1];
			else
				lru_new[k*WAY_W +: WAY_W] = order[k];
		end

		valid_new      = valid_row;
		valid_new[way] = 1'b1;
		tag_new        = tag_rd_q;
		dirty_new      = dirty_rd_q;
		if (hit) begin
			if (is_write_q)
				dirty_new[way] = 1'b1;
		end else begin
			tag_new[way*TAG_W +: TAG_W] = tag_q;
			dirty_new[way]              = is_write_q;
		end
	end

	assign acc_nxt  = sat_inc(acc_cnt_q);
	assign hit_nxt  = hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
	assign miss_nxt = hit ? miss_cnt_q : sat_inc(miss_cnt_q);
	assign wb_nxt   = wb ? sat_inc(wb_cnt_q) : wb_cnt_q;
	assign way_x    = (WAY_W + 2)'(way);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q  <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			wb_cnt_q   <= '0;
		end else if (cmd.commit) begin
			acc_cnt_q  <= acc_nxt;
			hit_cnt_q  <= hit_nxt;
			miss_cnt_q <= miss_nxt;
			wb_cnt_q   <= wb_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.hit             <= hit;
			rsp_q.wrote_back      <= wb;
			rsp_q.way_used        <= way_x[1:0];
			rsp_q.access_count    <= acc_nxt;
			rsp_q.hit_count       <= hit_nxt;
			rsp_q.miss_count      <= miss_nxt;
			rsp_q.writeback_count <= wb_nxt;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== hdl/set_assoc_cache_lru_writeback.sv =====
// Tag directory of a set-associative write-back cache, true-LRU replacement.
// req (sink): one word per access, action and byte address.
// rsp (source): one word per access - hit, dirty eviction, way used and the
//   saturating access, hit, miss and writeback counts after this access.
// cfg (sink): register writes (0 offset bits, 1 set index bits, 2 ways);
//   always ready, to be written only while no access is in flight.
// Timing: the accept edge reads the set's tag, valid, dirty and LRU rows;
//   the commit edge compares, updates the set and loads the result register.
//   No further access is taken until the last one has updated its set, as
//   the single-port set memories are read and then written.
// req is taken again as soon as the result is registered, so a further
//   access is read while the result waits; if rsp is still stalled the
//   update holds until the result register drains.
// Reset: all lines invalid, counters zero, every set's LRU order in way
//   order (kept by one written flag per set, no clearing pass), registers
//   to 6, 8 and 4. Lines are not flushed on register writes.
module set_assoc_cache_lru_writeback import sac_pkg::*; #(
	parameter int MAX_SETS  = DEF_MAX_SETS,
	parameter int MAX_WAYS  = DEF_MAX_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	sac_chan_if.sink    req,
	sac_chan_if.source  rsp,
	sac_chan_if.sink    cfg
);

	sac_cmd_t cmd;
	sac_cfg_t regs;

	sac_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	sac_datapath #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (regs),
		.req    (req.data),
		.rsp    (rsp.data)
	);

endmodule
